[sv/bcs_pkg.sv]
// bcs_pkg: shared types, signature tables and verdict codes for the binary content sniffer
// no dependencies; imported by bcs_scan, bcs_verdict and binary_content_sniffer_unit
package bcs_pkg;

  localparam int SIG_COUNT  = 10;
  localparam int SIG_MAXLEN = 11;
  localparam int POS_W      = $clog2(SIG_MAXLEN + 1);
  localparam int POS_SLOTS  = 1 << POS_W;
  localparam int KIND_W     = 4;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(SIG_MAXLEN);

  typedef enum logic [KIND_W-1:0] {
    KIND_TEXT  = 4'd0,
    KIND_PS    = 4'd1,
    KIND_PNG   = 4'd2,
    KIND_GIF87 = 4'd3,
    KIND_GIF89 = 4'd4,
    KIND_PDF   = 4'd5,
    KIND_U32BE = 4'd6,
    KIND_U32LE = 4'd7,
    KIND_JPEG  = 4'd8,
    KIND_U16BE = 4'd9,
    KIND_U16LE = 4'd10,
    KIND_ZERO  = 4'd11
  } kind_t;

  // signature lengths, in priority order
  localparam logic [POS_W-1:0] SIG_LEN [SIG_COUNT] = '{
    4'd11, 4'd8, 4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd2, 4'd2
  };

  // 1 where a signature means binary content
  localparam logic [SIG_COUNT-1:0] SIG_BINARY = 10'b00_1001_1110;

  // signature bytes, padded to a power-of-two row so any position indexes safely
  localparam logic [7:0] SIG_BYTES [SIG_COUNT][POS_SLOTS] = '{
    '{8'h25, 8'h21, 8'h50, 8'h53, 8'h2D, 8'h41, 8'h64, 8'h6F,
      8'h62, 8'h65, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'hFE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // running scan state of one buffer
  typedef struct packed {
    logic [SIG_COUNT-1:0] alive;
    logic [POS_W-1:0]     count;
    logic                 zero_seen;
  } scan_t;

  localparam scan_t SCAN_RESET = '{alive: '1, count: '0, zero_seen: 1'b0};

endpackage

[sv/bcs_scan.sv]
// bcs_scan: per-byte signature compare, position count and zero-byte tracking
// depends on bcs_pkg
module bcs_scan
  import bcs_pkg::*;
(
  input  scan_t      scan_cur,
  input  logic [7:0] data_byte,
  output scan_t      scan_nxt
);

  logic [SIG_COUNT-1:0] kill;

  // one byte compare per signature, only while inside that signature
  always_comb begin
    for (int k = 0; k < SIG_COUNT; k++) begin
      kill[k] = (scan_cur.count < SIG_LEN[k]) &&
                (SIG_BYTES[k][scan_cur.count] != data_byte);
    end
  end

  always_comb begin
    scan_nxt.alive     = scan_cur.alive & ~kill;
    scan_nxt.zero_seen = scan_cur.zero_seen | (data_byte == 8'h00);
    scan_nxt.count     = (scan_cur.count < POS_MAX) ? scan_cur.count + POS_W'(1) : POS_MAX;
  end

endmodule

[sv/bcs_verdict.sv]
// bcs_verdict: priority pick of the first fully matched signature, zero-byte fallback
// depends on bcs_pkg
module bcs_verdict
  import bcs_pkg::*;
(
  input  scan_t scan,
  output logic  is_binary,
  output kind_t kind
);

  always_comb begin
    kind      = KIND_TEXT;
    is_binary = 1'b0;
    // walk from lowest priority up so the highest-priority match wins
    for (int k = SIG_COUNT - 1; k >= 0; k--) begin
      if (scan.alive[k] && (scan.count >= SIG_LEN[k])) begin
        kind      = kind_t'(KIND_W'(k + 1));
        is_binary = SIG_BINARY[k];
      end
    end
    if ((kind == KIND_TEXT) && scan.zero_seen) begin
      kind      = KIND_ZERO;
      is_binary = 1'b1;
    end
  end

endmodule

[sv/binary_content_sniffer_unit.sv]
// binary_content_sniffer_unit: top level of the binary content sniffer
// depends on bcs_pkg, bcs_scan and bcs_verdict
//
// The sniffer takes a buffer one byte per transaction, in_last_byte marking
// its final byte, and at that byte gives one verdict transaction: out_is_binary
// and out_verdict_kind, the code of the deciding rule (0 plain text, 1..10 the
// leading signature that matched in priority order, 11 a zero byte somewhere
// in the buffer). Each byte is compared against every signature still within its
// length in the same cycle it is taken, so the block takes one byte per clock with
// no gaps while in_stall is low, across buffer boundaries too; the verdict shows on
// the output in the cycle after the final byte is taken and sits in an output
// register until it is taken. in_stall rises only while a verdict is held and
// stalled by the receiver. Bytes past the eleventh only feed zero detection, and
// the scan state returns to its reset values after each verdict.
module binary_content_sniffer_unit
  import bcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // byte input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  // verdict channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_is_binary,
  output logic [KIND_W-1:0]   out_verdict_kind
);

  scan_t             scan_r;
  scan_t             scan_step;
  scan_t             scan_nxt;
  logic              in_acc;
  logic              verdict_bin;
  kind_t             verdict_kind;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_is_binary_r;
  logic [KIND_W-1:0] out_verdict_kind_r;

  // a held verdict that is stalled blocks new bytes, anything else flows
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  bcs_scan u_scan (
    .scan_cur  (scan_r),
    .data_byte (in_data_byte),
    .scan_nxt  (scan_step)
  );

  // verdict from the state including the final byte
  bcs_verdict u_verdict (
    .scan      (scan_step),
    .is_binary (verdict_bin),
    .kind      (verdict_kind)
  );

  always_comb begin
    scan_nxt = scan_r;
    if (in_acc) begin
      scan_nxt = in_last_byte ? SCAN_RESET : scan_step;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_acc && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= SCAN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // verdict payload, loaded only when the output register is free
  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      out_is_binary_r    <= verdict_bin;
      out_verdict_kind_r <= verdict_kind;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_binary    = out_is_binary_r;
  assign out_verdict_kind = out_verdict_kind_r;

  // final byte always produces a verdict on the next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> out_valid_r)
    else $error("final byte taken but no verdict pending");

  // scan state is cleared after each verdict
  a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> (scan_r == SCAN_RESET))
    else $error("scan state not cleared after verdict");

  // position count saturates at the longest signature
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.count <= POS_MAX)
    else $error("byte position past saturation");

  // zero-byte verdict is always binary, and no code beyond zero-byte
  a_zero_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_verdict_kind_r <= KIND_ZERO) &&
                     ((out_verdict_kind_r != KIND_ZERO) || out_is_binary_r)))
    else $error("inconsistent verdict code");

  // zero detection is sticky within a buffer
  a_zero_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_r.zero_seen && !(in_acc && in_last_byte)) |=> scan_r.zero_seen)
    else $error("zero-byte flag dropped mid-buffer");

endmodule
